/* design/mmed_pkg.sv */
// ----------------------------------------------------------------------------
// mmed_pkg
// shared constants and types of the min/max envelope decimator
// ----------------------------------------------------------------------------
package mmed_pkg;

  // default parameter values
  localparam int SAMPLE_WIDTH_DEF       = 20;
  localparam int SMALL_BUCKET_LIMIT_DEF = 32;

  // fixed field widths
  localparam int LEN_W      = 16;
  localparam int CNT_W      = 13;
  localparam int IDX_W      = 12;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // q3.16 unity and the largest frame
  localparam int Q_ONE       = 65536;
  localparam int MAX_BUCKETS = 4096;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_LEN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = CFG_IDX_W'(1);

  // register reset values
  localparam logic [LEN_W-1:0] BUCKET_LEN_RESET   = LEN_W'(1);
  localparam logic [CNT_W-1:0] BUCKET_COUNT_RESET = CNT_W'(1024);

  typedef struct packed {
    logic [LEN_W-1:0] bucket_len;
    logic [CNT_W-1:0] bucket_count;
  } cfg_t;

endpackage

/* design/mmed_if.sv */
// ----------------------------------------------------------------------------
// mmed interfaces
// valid/ready channels for samples, bucket results and register writes
// ----------------------------------------------------------------------------
interface mmed_in_if #(
  parameter int SAMPLE_WIDTH = mmed_pkg::SAMPLE_WIDTH_DEF
);
  import mmed_pkg::*;
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           frame_start;

  modport source (output valid, output sample, output frame_start, input ready);
  modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

interface mmed_out_if #(
  parameter int SAMPLE_WIDTH = mmed_pkg::SAMPLE_WIDTH_DEF
);
  import mmed_pkg::*;
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] peak_high;
  logic signed [SAMPLE_WIDTH-1:0] peak_low;
  logic [IDX_W-1:0]               bucket_index;
  logic                           last;

  modport source (output valid, output peak_high, output peak_low,
                  output bucket_index, output last, input ready);
  modport sink   (input valid, input peak_high, input peak_low,
                  input bucket_index, input last, output ready);
endinterface

interface mmed_cfg_if;
  import mmed_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/mmed_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mmed_cfg_regs
// bucket length and bucket count registers behind the write channel
// ----------------------------------------------------------------------------
module mmed_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  mmed_cfg_if.sink      cfg,
  output mmed_pkg::cfg_t cfg_o
);
  import mmed_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg.ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg.valid) begin
      unique case (cfg.index)
        REG_BUCKET_LEN:   cfg_nxt.bucket_len   = cfg.data[LEN_W-1:0];
        REG_BUCKET_COUNT: cfg_nxt.bucket_count = cfg.data[CNT_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bucket_len   <= BUCKET_LEN_RESET;
      cfg_r.bucket_count <= BUCKET_COUNT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* design/mmed_bucket_core.sv */
// ----------------------------------------------------------------------------
// mmed_bucket_core
// per-sample bucket tracking, envelope fold and clamp
// ----------------------------------------------------------------------------
module mmed_bucket_core #(
  parameter int SAMPLE_WIDTH       = mmed_pkg::SAMPLE_WIDTH_DEF,
  parameter int SMALL_BUCKET_LIMIT = mmed_pkg::SMALL_BUCKET_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mmed_pkg::cfg_t                 cfg_i,
  input  logic                           accept_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           frame_start_i,
  output logic                           res_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] peak_high_o,
  output logic signed [SAMPLE_WIDTH-1:0] peak_low_o,
  output logic [mmed_pkg::IDX_W-1:0]     bucket_index_o,
  output logic                           last_o
);
  import mmed_pkg::*;

  // clamp domain wide enough to hold plus and minus one
  localparam int CW = (SAMPLE_WIDTH > 18) ? SAMPLE_WIDTH : 18;
  localparam logic signed [CW-1:0] POS_ONE = CW'(Q_ONE);
  localparam logic signed [CW-1:0] NEG_ONE = -CW'(Q_ONE);

  logic signed [SAMPLE_WIDTH-1:0] run_max_r, run_max_nxt;
  logic signed [SAMPLE_WIDTH-1:0] run_min_r, run_min_nxt;
  logic [LEN_W-1:0]               count_r, count_nxt;
  logic [CNT_W-1:0]               bucket_r, bucket_nxt;
  logic                           done_r, done_nxt;

  logic [LEN_W-1:0]               len_eff;
  logic [CNT_W-1:0]               cnt_eff;
  logic                           big;
  logic [LEN_W-1:0]               sc;
  logic [CNT_W-1:0]               cb;
  logic                           fd;
  logic                           close;
  logic                           is_last;
  logic signed [SAMPLE_WIDTH-1:0] hi, lo;
  logic signed [CW-1:0]           hi_w, lo_w;

  always_comb begin
    len_eff = (cfg_i.bucket_len == '0) ? LEN_W'(1) : cfg_i.bucket_len;
    if (cfg_i.bucket_count == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (cfg_i.bucket_count > CNT_W'(MAX_BUCKETS)) begin
      cnt_eff = CNT_W'(MAX_BUCKETS);
    end else begin
      cnt_eff = cfg_i.bucket_count;
    end
    big = len_eff > LEN_W'(SMALL_BUCKET_LIMIT);

    // frame start restarts counting on this very sample
    sc = frame_start_i ? '0 : count_r;
    cb = frame_start_i ? '0 : bucket_r;
    fd = frame_start_i ? 1'b0 : done_r;

    run_max_nxt = run_max_r;
    run_min_nxt = run_min_r;
    if (sc == '0) begin
      run_max_nxt = sample_i;
      run_min_nxt = sample_i;
    end else if (big) begin
      if (sample_i > run_max_r) run_max_nxt = sample_i;
      if (sample_i < run_min_r) run_min_nxt = sample_i;
    end

    close   = ({1'b0, sc} + (LEN_W+1)'(1)) >= {1'b0, len_eff};
    is_last = ({1'b0, cb} + (CNT_W+1)'(1)) >= {1'b0, cnt_eff};

    // in tracking mode (bucket_len above SMALL_BUCKET_LIMIT) same-sign buckets collapse onto one value
    hi = run_max_nxt;
    lo = run_min_nxt;
    if (big) begin
      if (hi[SAMPLE_WIDTH-1] && lo[SAMPLE_WIDTH-1]) begin
        hi = lo;
      end else if (!hi[SAMPLE_WIDTH-1] && (hi != '0) &&
                   !lo[SAMPLE_WIDTH-1] && (lo != '0)) begin
        lo = hi;
      end
    end
    hi_w = CW'(hi);
    lo_w = CW'(lo);
    if (hi_w > POS_ONE) hi_w = POS_ONE;
    if (lo_w < NEG_ONE) lo_w = NEG_ONE;

    count_nxt  = count_r;
    bucket_nxt = bucket_r;
    done_nxt   = done_r;
    if (accept_i && !fd) begin
      if (close) begin
        count_nxt  = '0;
        bucket_nxt = is_last ? cb : cb + CNT_W'(1);
        done_nxt   = is_last;
      end else begin
        count_nxt  = sc + LEN_W'(1);
        bucket_nxt = cb;
        done_nxt   = 1'b0;
      end
    end
  end

  assign res_valid_o    = accept_i && !fd && close;
  assign peak_high_o    = hi_w[SAMPLE_WIDTH-1:0];
  assign peak_low_o     = lo_w[SAMPLE_WIDTH-1:0];
  assign bucket_index_o = cb[IDX_W-1:0];
  assign last_o         = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      bucket_r <= '0;
      done_r   <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      bucket_r <= bucket_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_i && !fd) begin
      run_max_r <= run_max_nxt;
      run_min_r <= run_min_nxt;
    end
  end

  a_done_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (count_r == '0))
    else $error("frame done with a part-filled bucket");

  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    !bucket_r[CNT_W-1])
    else $error("bucket position beyond the largest frame");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_o && last_o) |=> done_r)
    else $error("final bucket did not end the frame");

endmodule

/* design/mmed_out_buf.sv */
// ----------------------------------------------------------------------------
// mmed_out_buf
// two-entry skid buffer holding bucket results for the output channel
// ----------------------------------------------------------------------------
module mmed_out_buf #(
  parameter int SAMPLE_WIDTH = mmed_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push_i,
  input  logic signed [SAMPLE_WIDTH-1:0] peak_high_i,
  input  logic signed [SAMPLE_WIDTH-1:0] peak_low_i,
  input  logic [mmed_pkg::IDX_W-1:0]     bucket_index_i,
  input  logic                           last_i,
  output logic                           room_o,
  mmed_out_if.source                     out
);
  import mmed_pkg::*;

  localparam int EW = 2*SAMPLE_WIDTH + IDX_W + 1;

  logic [EW-1:0] main_r, main_nxt;
  logic [EW-1:0] skid_r, skid_nxt;
  logic          main_v_r, main_v_nxt;
  logic          skid_v_r, skid_v_nxt;
  logic [EW-1:0] din;
  logic          pop;

  assign din = {peak_high_i, peak_low_i, bucket_index_i, last_i};
  assign pop = main_v_r && out.ready;

  always_comb begin
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = push_i;
        if (push_i) skid_nxt = din;
      end else begin
        main_v_nxt = push_i;
        if (push_i) main_nxt = din;
      end
    end else if (push_i) begin
      if (!main_v_r) begin
        main_nxt   = din;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = din;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  // room is registered so the input side never waits on out.ready
  assign room_o           = !skid_v_r;
  assign out.valid        = main_v_r;
  assign out.peak_high    = main_r[EW-1 -: SAMPLE_WIDTH];
  assign out.peak_low     = main_r[EW-1-SAMPLE_WIDTH -: SAMPLE_WIDTH];
  assign out.bucket_index = main_r[IDX_W:1];
  assign out.last         = main_r[0];

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held with empty head");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !skid_v_r)
    else $error("result pushed into a full buffer");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(main_v_r && !out.ready && push_i))
    else $error("skid entry filled without a stalled head");

endmodule

/* design/min_max_envelope_decimator_core.sv */
// ----------------------------------------------------------------------------
// min_max_envelope_decimator_core
// reduces a sample stream to one clamped min/max envelope result per bucket
// ----------------------------------------------------------------------------
// a bucket result is registered in the result buffer before it is offered
// throughput: one sample per cycle, set by the combinational bucket update
// output stalls are absorbed by a two-entry result buffer; samples stop only
//   when both entries are full
// reset (rst_n low, synchronous): counters and frame state cleared, buffer
//   emptied, bucket_len back to 1 and bucket_count back to 1024
// ----------------------------------------------------------------------------
module min_max_envelope_decimator_core #(
  parameter int SAMPLE_WIDTH       = mmed_pkg::SAMPLE_WIDTH_DEF,
  parameter int SMALL_BUCKET_LIMIT = mmed_pkg::SMALL_BUCKET_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mmed_in_if.sink     in_chan,
  mmed_out_if.source  out_chan,
  mmed_cfg_if.sink    cfg_chan
);
  import mmed_pkg::*;

  cfg_t                           cfg;
  logic                           in_accept;
  logic                           res_valid;
  logic signed [SAMPLE_WIDTH-1:0] res_high;
  logic signed [SAMPLE_WIDTH-1:0] res_low;
  logic [IDX_W-1:0]               res_index;
  logic                           res_last;
  logic                           buf_room;

  // register file, to be written by the user only while the block is idle; the block itself does not enforce this
  mmed_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_chan),
    .cfg_o (cfg)
  );

  // a sample transaction completes on valid and ready together
  assign in_chan.ready = buf_room;
  assign in_accept     = in_chan.valid && in_chan.ready;

  // bucket bookkeeping and envelope, all in the accepting cycle
  mmed_bucket_core #(
    .SAMPLE_WIDTH       (SAMPLE_WIDTH),
    .SMALL_BUCKET_LIMIT (SMALL_BUCKET_LIMIT)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_i          (cfg),
    .accept_i       (in_accept),
    .sample_i       (in_chan.sample),
    .frame_start_i  (in_chan.frame_start),
    .res_valid_o    (res_valid),
    .peak_high_o    (res_high),
    .peak_low_o     (res_low),
    .bucket_index_o (res_index),
    .last_o         (res_last)
  );

  // result register with skid entry, decoupling both channels
  mmed_out_buf #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .push_i         (res_valid),
    .peak_high_i    (res_high),
    .peak_low_i     (res_low),
    .bucket_index_i (res_index),
    .last_i         (res_last),
    .room_o         (buf_room),
    .out            (out_chan)
  );

  // results only ever come from accepted samples
  a_result_needs_sample: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> in_accept)
    else $error("result raised without a sample transaction");

  // the upper envelope never drops below the lower one, except where one of them is clamped to plus or minus one
  a_envelope_order: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res_high >= res_low || res_high == SAMPLE_WIDTH'(Q_ONE)
                   || res_low == -SAMPLE_WIDTH'(Q_ONE)))
    else $error("upper envelope below lower envelope");

  // with room there is always space for the next result
  a_room_means_space: assert property (@(posedge clk) disable iff (!rst_n)
    (buf_room && res_valid) |=> out_chan.valid)
    else $error("result lost on entry to the buffer");

endmodule

/* tb/sv/min_max_envelope_decimator_core_tb.sv */
// ----------------------------------------------------------------------------
// min_max_envelope_decimator_core_tb
// drives sample transactions and register writes into the envelope decimator
// and checks every bucket result against an in-bench prediction or a spelt-out
// expected value of the envelope, index and end-of-frame flag
// ----------------------------------------------------------------------------
module min_max_envelope_decimator_core_tb;
  import mmed_pkg::*;

  localparam int SW           = SAMPLE_WIDTH_DEF;
  localparam int SMALL_LIMIT  = SMALL_BUCKET_LIMIT_DEF;
  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 6;
  localparam int SETTLE_CYCLES = 4;   // a result is registered before it appears
  localparam int END_CYCLES   = 8;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 95;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTS  = 10;

  // index outside the register map, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(2);

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // sign bias of the samples of one bucket
  typedef enum int {MIX_POS, MIX_NEG, MIX_ANY, MIX_EDGE} sign_mix_t;

  typedef struct {
    logic signed [SW-1:0] high;
    logic signed [SW-1:0] low;
    logic [IDX_W-1:0]     idx;
    logic                 last;
  } bucket_t;

  // one line of the directed plan: a register write or a sample, the latter
  // optionally with its result spelt out
  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    int                    sample;
    logic                  fs;
    bit                    typed;
    bit                    has_res;
    bucket_t               res;
  } row_t;

  logic clk;
  logic rst_n;

  mmed_in_if  in_if ();
  mmed_out_if out_if ();
  mmed_cfg_if cfg_if ();

  min_max_envelope_decimator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // results still owed by the block, oldest first
  bucket_t envelope_due[$];
  row_t    plan[$];

  int bad_count      = 0;
  int cycle_count    = 0;
  int sender_idle_pct = 0;
  int recv_idle_pct  = 0;
  int hold_req       = 0;   // bumped by the stimulus to ask for a long stall
  int hold_seen      = 0;
  int hold_left      = 0;

  // predicted block state: registers, bucket accumulators and frame progress
  logic [LEN_W-1:0]     p_len;
  logic [CNT_W-1:0]     p_cnt;
  logic signed [SW-1:0] p_max;
  logic signed [SW-1:0] p_min;
  logic [LEN_W-1:0]     p_count;
  logic [CNT_W-1:0]     p_bucket;
  logic                 p_done;

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // run limit, well beyond the slowest legal run
  initial begin
    while (cycle_count <= LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic flag_error(input string msg);
    bad_count++;
    if (bad_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // appends a line to the directed plan
  function automatic void add_row(input row_t r);
    plan.insert(plan.size(), r);
  endfunction

  // records a result the block now owes
  function automatic void owe_result(input bucket_t b);
    envelope_due.insert(envelope_due.size(), b);
  endfunction

  // --------------------------------------------------------------------------
  // envelope prediction for one accepted sample; returns 1 when a bucket closes
  // --------------------------------------------------------------------------
  function automatic bit envelope_step(input logic signed [SW-1:0] s, input logic fs,
                                       output bucket_t r);
    int unsigned len;
    int unsigned cnt;
    int          hi;
    int          lo;
    bit          fin;
    r = '{default: '0};
    // zero length behaves as one, bucket count is folded into 1..4096
    len = (p_len == 0) ? 1 : p_len;
    cnt = (p_cnt == 0) ? 1 : ((p_cnt > MAX_BUCKETS) ? MAX_BUCKETS : p_cnt);

    // frame start restarts counting and takes this sample as bucket 0
    if (fs) begin
      p_count  = '0;
      p_bucket = '0;
      p_done   = 1'b0;
    end
    // finished frame: drop everything until the next frame start
    if (p_done) return 1'b0;

    if (p_count == 0) begin
      p_max = s;
      p_min = s;
    end else if (len > SMALL_LIMIT) begin
      if (s > p_max) p_max = s;
      if (s < p_min) p_min = s;
    end

    // bucket still open
    if (p_count + 1 < len) begin
      p_count = p_count + 1'b1;
      return 1'b0;
    end

    hi = p_max;
    lo = p_min;
    // in tracking mode a one-signed bucket collapses onto its outer value
    if (len > SMALL_LIMIT) begin
      if (hi < 0 && lo < 0) hi = lo;
      else if (hi > 0 && lo > 0) lo = hi;
    end
    if (hi > Q_ONE) hi = Q_ONE;
    if (lo < -Q_ONE) lo = -Q_ONE;
    fin = (p_bucket + 1 >= cnt);

    r.high = SW'(hi);
    r.low  = SW'(lo);
    r.idx  = p_bucket[IDX_W-1:0];
    r.last = fin;

    p_count = '0;
    if (fin) p_done = 1'b1;
    else p_bucket = p_bucket + 1'b1;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // sample source and register writes
  // --------------------------------------------------------------------------
  // offers one sample transaction and predicts its outcome once accepted
  task automatic offer_sample(input logic signed [SW-1:0] s, input logic fs,
                              output bucket_t r, output bit has);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.sample      <= s;
    in_if.frame_start <= fs;
    do @(posedge clk); while (!in_if.ready);
    has = envelope_step(s, fs, r);
  endtask

  // lets the block run dry: nothing owed and its pipeline flushed
  task automatic wait_idle(input int settle);
    in_if.valid <= 1'b0;
    while (envelope_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    wait_idle(SETTLE_CYCLES);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_BUCKET_LEN) p_len = d[LEN_W-1:0];
    else if (idx == REG_BUCKET_COUNT) p_cnt = d[CNT_W-1:0];
  endtask

  // --------------------------------------------------------------------------
  // directed plan rows
  // --------------------------------------------------------------------------
  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] d);
    row_t r;
    r = '{kind: ROW_CFG, reg_idx: idx, reg_data: d, sample: 0, fs: 1'b0,
          typed: 1'b0, has_res: 1'b0, res: '{default: '0}};
    return r;
  endfunction

  // sample checked against the prediction
  function automatic row_t item_row(input int s, input logic fs);
    row_t r;
    r = cfg_row('0, '0);
    r.kind   = ROW_ITEM;
    r.sample = s;
    r.fs     = fs;
    return r;
  endfunction

  // sample known to give no result
  function automatic row_t quiet_row(input int s, input logic fs);
    row_t r;
    r = item_row(s, fs);
    r.typed = 1'b1;
    return r;
  endfunction

  // sample whose bucket result is spelt out
  function automatic row_t bucket_row(input int s, input logic fs, input int hi,
                                      input int lo, input int idx, input logic fin);
    row_t r;
    r = quiet_row(s, fs);
    r.has_res = 1'b1;
    r.res     = '{high: SW'(hi), low: SW'(lo), idx: IDX_W'(idx), last: fin};
    return r;
  endfunction

  // random sample of the requested sign bias, with some pure noise mixed in
  function automatic logic signed [SW-1:0] pick_sample(input sign_mix_t mix);
    int v;
    if ($urandom_range(24) == 0) mix = MIX_ANY;
    case (mix)
      MIX_POS: v = int'($urandom_range(524287, 1));
      MIX_NEG: v = -int'($urandom_range(524288, 1));
      MIX_ANY: v = int'($urandom);
      default: begin
        case ($urandom_range(4))
          0:       v = Q_ONE + int'($urandom_range(6)) - 3;
          1:       v = -Q_ONE + int'($urandom_range(6)) - 3;
          2:       v = 524287;
          3:       v = -524288;
          default: v = 0;
        endcase
      end
    endcase
    return SW'(v);
  endfunction

  // --------------------------------------------------------------------------
  // result sink: random or long stalls, each transaction checked in order
  // --------------------------------------------------------------------------
  initial begin
    bucket_t want;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (envelope_due.size() == 0) begin
          flag_error($sformatf("unexpected result: hi=%0d lo=%0d idx=%0d last=%0b",
                               out_if.peak_high, out_if.peak_low,
                               out_if.bucket_index, out_if.last));
        end else begin
          want = envelope_due.pop_front();
          if (out_if.peak_high !== want.high || out_if.peak_low !== want.low ||
              out_if.bucket_index !== want.idx || out_if.last !== want.last) begin
            flag_error($sformatf(
              "mismatch: expected hi=%0d lo=%0d idx=%0d last=%0b, got hi=%0d lo=%0d idx=%0d last=%0b",
              want.high, want.low, want.idx, want.last, out_if.peak_high,
              out_if.peak_low, out_if.bucket_index, out_if.last));
          end
        end
      end
      // long hold-off when asked, otherwise random back-pressure
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    bucket_t   r;
    bit        has;
    logic      fs;
    int        counted;
    int        len_pick;
    int        cnt_pick;
    sign_mix_t mix;

    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.sample      <= '0;
    in_if.frame_start <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= '0;
    cfg_if.data       <= '0;

    p_len    = BUCKET_LEN_RESET;
    p_cnt    = BUCKET_COUNT_RESET;
    p_max    = '0;
    p_min    = '0;
    p_count  = '0;
    p_bucket = '0;
    p_done   = 1'b0;
    mix      = MIX_ANY;

    // reset values: one-sample buckets, so every sample is its own result,
    // and the block runs as if a frame had begun
    add_row(bucket_row(0, 1'b0, 0, 0, 0, 1'b0));
    add_row(bucket_row(524287, 1'b0, Q_ONE, 524287, 1, 1'b0));
    add_row(bucket_row(-524288, 1'b0, -524288, -Q_ONE, 2, 1'b0));
    add_row(bucket_row(Q_ONE, 1'b0, Q_ONE, Q_ONE, 3, 1'b0));
    add_row(bucket_row(Q_ONE + 1, 1'b0, Q_ONE, Q_ONE + 1, 4, 1'b0));
    add_row(bucket_row(-Q_ONE - 1, 1'b0, -Q_ONE - 1, -Q_ONE, 5, 1'b0));
    add_row(bucket_row(12345, 1'b1, 12345, 12345, 0, 1'b0));
    // zero length acts as one, two-bucket frame, drops after frame end
    add_row(cfg_row(REG_BUCKET_LEN, 16'd0));
    add_row(cfg_row(REG_BUCKET_COUNT, 16'd2));
    add_row(bucket_row(100, 1'b1, 100, 100, 0, 1'b0));
    add_row(bucket_row(-100, 1'b0, -100, -100, 1, 1'b1));
    add_row(quiet_row(5, 1'b0));
    add_row(bucket_row(7, 1'b1, 7, 7, 0, 1'b0));
    // longest bucket and an over-range count, then shrink the bucket mid-way
    add_row(cfg_row(REG_BUCKET_LEN, 16'hFFFF));
    add_row(cfg_row(REG_BUCKET_COUNT, 16'hFFFF));
    add_row(quiet_row(300, 1'b1));
    add_row(quiet_row(400, 1'b0));
    add_row(cfg_row(REG_BUCKET_LEN, 16'd2));
    add_row(item_row(500, 1'b0));
    // count lowered below the current bucket: frame ends with the current bucket
    add_row(cfg_row(REG_BUCKET_COUNT, 16'd1));
    add_row(quiet_row(600, 1'b0));
    add_row(bucket_row(700, 1'b0, 600, 600, 1, 1'b1));
    add_row(quiet_row(800, 1'b0));
    // write outside the map, zero count acting as one
    add_row(cfg_row(REG_UNUSED, 16'hFFFF));
    add_row(cfg_row(REG_BUCKET_COUNT, 16'd0));
    add_row(quiet_row(900, 1'b1));
    add_row(bucket_row(-900, 1'b0, 900, 900, 0, 1'b1));
    add_row(cfg_row(REG_BUCKET_LEN, 16'd3));
    add_row(cfg_row(REG_BUCKET_COUNT, 16'd4096));
    add_row(item_row(-1, 1'b1));
    add_row(item_row(1, 1'b0));
    add_row(item_row(2, 1'b0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        offer_sample(SW'(plan[i].sample), plan[i].fs, r, has);
        if (plan[i].typed) begin
          if (plan[i].has_res) owe_result(plan[i].res);
        end else if (has) begin
          owe_result(r);
        end
      end
    end

    // random part: one register setting per phase, idling pattern by thirds
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        sender_idle_pct = 7;
        recv_idle_pct   <= 46;
      end else if (ph < 6) begin
        sender_idle_pct = 46;
        recv_idle_pct   <= 7;
      end else begin
        sender_idle_pct = 0;
        recv_idle_pct   <= 0;
      end

      case ($urandom_range(5))
        0:       len_pick = 1;
        1:       len_pick = $urandom_range(4, 2);
        2:       len_pick = $urandom_range(31, 5);
        3:       len_pick = SMALL_LIMIT;
        4:       len_pick = SMALL_LIMIT + 1;
        default: len_pick = $urandom_range(48, 34);
      endcase
      case ($urandom_range(4))
        0:       cnt_pick = $urandom_range(3, 1);
        1:       cnt_pick = $urandom_range(16, 4);
        2:       cnt_pick = MAX_BUCKETS;
        3:       cnt_pick = 0;
        default: cnt_pick = 8191;
      endcase
      // first phase: a result per sample and a long sink stall, so the
      // result buffer fills and the input has to wait
      if (ph == 0) begin
        len_pick = 1;
        cnt_pick = MAX_BUCKETS;
      end
      write_reg(REG_BUCKET_LEN, CFG_DATA_W'(len_pick));
      write_reg(REG_BUCKET_COUNT, CFG_DATA_W'(cnt_pick));
      if (ph == 0) hold_req <= hold_req + 1;

      counted = 0;
      while (counted < PHASE_ITEMS) begin
        // new sign bias at each bucket boundary
        if (p_count == 0) mix = sign_mix_t'($urandom_range(3));
        // mostly well-formed frames: restart soon after a frame ends,
        // and only rarely break into a running frame
        if (p_done) fs = ($urandom_range(9) != 0);
        else fs = ($urandom_range(99) < 2);
        if (!(p_done && !fs)) counted++;
        offer_sample(pick_sample(mix), fs, r, has);
        if (has) owe_result(r);
      end
    end

    // drain, then allow the pipeline to settle
    wait_idle(END_CYCLES);
    if (envelope_due.size() != 0) flag_error("results still owed at end of run");

    if (bad_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* min_max_envelope_decimator_core.f */
design/mmed_pkg.sv
design/mmed_if.sv
design/mmed_cfg_regs.sv
design/mmed_bucket_core.sv
design/mmed_out_buf.sv
design/min_max_envelope_decimator_core.sv
tb/sv/min_max_envelope_decimator_core_tb.sv
